/* design/glpw_pkg.sv */
// ----------------------------------------------------------------------------
// glpw_pkg
// Shared constants for the 3d grid line path walker: default coordinate
// width, segment queue depth and major axis codes.
// ----------------------------------------------------------------------------
package glpw_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

/* design/grid_line_path_walker_3d.sv */
// ----------------------------------------------------------------------------
// grid_line_path_walker_3d
// Walks 3d Bresenham lines between successive path nodes on a signed grid.
// ----------------------------------------------------------------------------
// node channel: node_valid / node_stall carry one node (x, y, z, new_path).
// a node with new_path set, or the first node after reset, only starts a
// path and gives no points. every later node gives the grid points of the
// line from the previous node to it, end point included; the joint point
// shared with the previous line is given once.
// point channel: point_valid / point_stall carry one grid point per transfer;
// last_point marks the final point of a node.
// the first point of a node passes through the segment queue, the walker
// registers and the output register. the walker works on one node at a
// time and steps one point per cycle while the output is not stalled. a
// two-entry segment queue lets nodes be taken while the walker is busy;
// node_stall rises when that queue is full.
// a stalled point holds in the output register and the walker waits.
// reset empties the queue, drops any pending point and forgets the path.
// ----------------------------------------------------------------------------
module grid_line_path_walker_3d #(
  parameter int COORD_BITS = glpw_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         node_valid,
  output logic                         node_stall,
  input  logic signed [COORD_BITS-1:0] node_x,
  input  logic signed [COORD_BITS-1:0] node_y,
  input  logic signed [COORD_BITS-1:0] node_z,
  input  logic                         new_path,
  output logic                         point_valid,
  input  logic                         point_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic                         last_point
);

  localparam int SEG_BITS = 3 * COORD_BITS + 3 + 2 + 3 * COORD_BITS + 1;

  logic                seg_push;
  logic                seg_pop;
  logic [SEG_BITS-1:0] push_data;
  logic [SEG_BITS-1:0] pop_data;
  logic                queue_full;
  logic                queue_empty;

  glpw_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_x     (node_x),
    .node_y     (node_y),
    .node_z     (node_z),
    .new_path   (new_path),
    .queue_full (queue_full),
    .seg_push   (seg_push),
    .seg_data   (push_data)
  );

  glpw_queue #(.WIDTH(SEG_BITS), .DEPTH(glpw_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (seg_push),
    .push_data (push_data),
    .pop       (seg_pop),
    .pop_data  (pop_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  glpw_walk #(.COORD_BITS(COORD_BITS)) u_walk (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .seg_data    (pop_data),
    .seg_pop     (seg_pop),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .last_point  (last_point)
  );

endmodule

/* design/glpw_front.sv */
// ----------------------------------------------------------------------------
// glpw_front
// Accepts path nodes, keeps the previous node and path state, and turns each
// node that extends a path into a segment descriptor for the walker.
// ----------------------------------------------------------------------------
module glpw_front #(
  parameter int COORD_BITS = glpw_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         node_valid,
  output logic                         node_stall,
  input  logic signed [COORD_BITS-1:0] node_x,
  input  logic signed [COORD_BITS-1:0] node_y,
  input  logic signed [COORD_BITS-1:0] node_z,
  input  logic                         new_path,
  input  logic                         queue_full,
  output logic                         seg_push,
  output logic [3*COORD_BITS+3+2+3*COORD_BITS+1-1:0] seg_data
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic                         neg_x;
    logic                         neg_y;
    logic                         neg_z;
    logic [1:0]                   major;
    logic [COORD_BITS-1:0]        dm;
    logic [COORD_BITS-1:0]        da;
    logic [COORD_BITS-1:0]        db;
    logic                         skip;
  } seg_t;

  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] prev_z;
  logic                         have_prev;
  logic                         last_valid;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] dz;
  logic signed [COORD_BITS:0] ax_full;
  logic signed [COORD_BITS:0] ay_full;
  logic signed [COORD_BITS:0] az_full;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic [COORD_BITS-1:0]      adz;
  logic                       accept;
  logic                       starts;
  seg_t                       seg;

  assign node_stall = queue_full;
  assign accept     = node_valid && !node_stall;
  assign starts     = new_path || !have_prev;

  assign dx = {node_x[COORD_BITS-1], node_x} - {prev_x[COORD_BITS-1], prev_x};
  assign dy = {node_y[COORD_BITS-1], node_y} - {prev_y[COORD_BITS-1], prev_y};
  assign dz = {node_z[COORD_BITS-1], node_z} - {prev_z[COORD_BITS-1], prev_z};
  assign ax_full = dx[COORD_BITS] ? -dx : dx;
  assign ay_full = dy[COORD_BITS] ? -dy : dy;
  assign az_full = dz[COORD_BITS] ? -dz : dz;
  assign adx = ax_full[COORD_BITS-1:0];
  assign ady = ay_full[COORD_BITS-1:0];
  assign adz = az_full[COORD_BITS-1:0];

  always_comb begin
    seg.start_x = prev_x;
    seg.start_y = prev_y;
    seg.start_z = prev_z;
    seg.neg_x   = dx[COORD_BITS];
    seg.neg_y   = dy[COORD_BITS];
    seg.neg_z   = dz[COORD_BITS];
    seg.skip    = last_valid;
    if (adx >= ady && adx >= adz) begin
      seg.major = glpw_pkg::AXIS_X;
      seg.dm    = adx;
      seg.da    = ady;
      seg.db    = adz;
    end else if (ady >= adz) begin
      seg.major = glpw_pkg::AXIS_Y;
      seg.dm    = ady;
      seg.da    = adx;
      seg.db    = adz;
    end else begin
      seg.major = glpw_pkg::AXIS_Z;
      seg.dm    = adz;
      seg.da    = adx;
      seg.db    = ady;
    end
  end

  // a repeated node after an emitted point gives nothing
  assign seg_push = accept && !starts && !(seg.dm == '0 && last_valid);
  assign seg_data = seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      last_valid <= 1'b0;
    end else if (accept) begin
      have_prev  <= 1'b1;
      last_valid <= !starts;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x <= node_x;
      prev_y <= node_y;
      prev_z <= node_z;
    end
  end

endmodule

/* design/glpw_queue.sv */
// ----------------------------------------------------------------------------
// glpw_queue
// Short first-in first-out queue of segment descriptors between the front
// and the walker.
// ----------------------------------------------------------------------------
module glpw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = glpw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* design/glpw_walk.sv */
// ----------------------------------------------------------------------------
// glpw_walk
// Takes segment descriptors and steps the Bresenham line along the major
// axis, one grid point per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module glpw_walk #(
  parameter int COORD_BITS = glpw_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         queue_empty,
  input  logic [3*COORD_BITS+3+2+3*COORD_BITS+1-1:0] seg_data,
  output logic                         seg_pop,
  output logic                         point_valid,
  input  logic                         point_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic                         last_point
);

  localparam int EW = COORD_BITS + 3;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic                         neg_x;
    logic                         neg_y;
    logic                         neg_z;
    logic [1:0]                   major;
    logic [COORD_BITS-1:0]        dm;
    logic [COORD_BITS-1:0]        da;
    logic [COORD_BITS-1:0]        db;
    logic                         skip;
  } seg_t;

  seg_t                         seg;
  logic                         state;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         neg_x;
  logic                         neg_y;
  logic                         neg_z;
  logic [1:0]                   major;
  logic [COORD_BITS-1:0]        remain;
  logic                         skip;
  logic signed [EW-1:0]         err_a;
  logic signed [EW-1:0]         err_b;
  logic [EW-1:0]                dm2;
  logic [EW-1:0]                da2;
  logic [EW-1:0]                db2;

  logic                         out_free;
  logic                         emit;
  logic                         advance;
  logic                         step_a;
  logic                         step_b;
  logic                         move_x;
  logic                         move_y;
  logic                         move_z;
  logic signed [EW-1:0]         err_a_next;
  logic signed [EW-1:0]         err_b_next;

  assign seg      = seg_data;
  assign out_free = !point_valid || !point_stall;
  assign seg_pop  = (state == ST_IDLE) && !queue_empty;
  assign emit     = (state == ST_RUN) && out_free && !skip;
  assign advance  = (state == ST_RUN) && out_free && (skip || remain != '0);

  assign step_a = !err_a[EW-1];
  assign step_b = !err_b[EW-1];

  always_comb begin
    move_x = 1'b0;
    move_y = 1'b0;
    move_z = 1'b0;
    unique case (major)
      glpw_pkg::AXIS_X: begin
        move_x = 1'b1;
        move_y = step_a;
        move_z = step_b;
      end
      glpw_pkg::AXIS_Y: begin
        move_y = 1'b1;
        move_x = step_a;
        move_z = step_b;
      end
      glpw_pkg::AXIS_Z: begin
        move_z = 1'b1;
        move_x = step_a;
        move_y = step_b;
      end
      default: begin
        move_x = 1'b0;
      end
    endcase
    err_a_next = (step_a ? err_a - dm2 : err_a) + da2;
    err_b_next = (step_b ? err_b - dm2 : err_b) + db2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && remain == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seg_pop) begin
      pos_x  <= seg.start_x;
      pos_y  <= seg.start_y;
      pos_z  <= seg.start_z;
      neg_x  <= seg.neg_x;
      neg_y  <= seg.neg_y;
      neg_z  <= seg.neg_z;
      major  <= seg.major;
      remain <= seg.dm;
      skip   <= seg.skip;
      dm2    <= {{(EW-COORD_BITS-1){1'b0}}, seg.dm, 1'b0};
      da2    <= {{(EW-COORD_BITS-1){1'b0}}, seg.da, 1'b0};
      db2    <= {{(EW-COORD_BITS-1){1'b0}}, seg.db, 1'b0};
      err_a  <= {{(EW-COORD_BITS-1){1'b0}}, seg.da, 1'b0}
              - {{(EW-COORD_BITS){1'b0}}, seg.dm};
      err_b  <= {{(EW-COORD_BITS-1){1'b0}}, seg.db, 1'b0}
              - {{(EW-COORD_BITS){1'b0}}, seg.dm};
    end else if (advance) begin
      skip   <= 1'b0;
      remain <= remain - COORD_BITS'(1);
      err_a  <= err_a_next;
      err_b  <= err_b_next;
      if (move_x) begin
        pos_x <= neg_x ? pos_x - COORD_BITS'(1) : pos_x + COORD_BITS'(1);
      end
      if (move_y) begin
        pos_y <= neg_y ? pos_y - COORD_BITS'(1) : pos_y + COORD_BITS'(1);
      end
      if (move_z) begin
        pos_z <= neg_z ? pos_z - COORD_BITS'(1) : pos_z + COORD_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (out_free) begin
      point_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x    <= pos_x;
      point_y    <= pos_y;
      point_z    <= pos_z;
      last_point <= (remain == '0);
    end
  end

endmodule

/* design/glpw_checker.sv */
// ----------------------------------------------------------------------------
// glpw_checker
// Port-level checks for the path walker: node and point channel hold, reset,
// and continuity of the points within one node.
// ----------------------------------------------------------------------------
module glpw_checker #(
  parameter int COORD_BITS = glpw_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         node_valid,
  input logic                         node_stall,
  input logic signed [COORD_BITS-1:0] node_x,
  input logic signed [COORD_BITS-1:0] node_y,
  input logic signed [COORD_BITS-1:0] node_z,
  input logic                         new_path,
  input logic                         point_valid,
  input logic                         point_stall,
  input logic signed [COORD_BITS-1:0] point_x,
  input logic signed [COORD_BITS-1:0] point_y,
  input logic signed [COORD_BITS-1:0] point_z,
  input logic                         last_point
);

  logic                  mid_walk;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [COORD_BITS-1:0] prev_z;
  logic [COORD_BITS-1:0] step_x;
  logic [COORD_BITS-1:0] step_y;
  logic [COORD_BITS-1:0] step_z;
  logic                  unit_x;
  logic                  unit_y;
  logic                  unit_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_walk <= 1'b0;
    end else begin
      mid_walk <= point_valid && !point_stall && !last_point;
    end
  end

  always_ff @(posedge clk) begin
    prev_x <= point_x;
    prev_y <= point_y;
    prev_z <= point_z;
  end

  assign step_x = point_x - prev_x;
  assign step_y = point_y - prev_y;
  assign step_z = point_z - prev_z;
  assign unit_x = (step_x == '0) || (step_x == COORD_BITS'(1)) || (step_x == '1);
  assign unit_y = (step_y == '0) || (step_y == COORD_BITS'(1)) || (step_y == '1);
  assign unit_z = (step_z == '0) || (step_z == COORD_BITS'(1)) || (step_z == '1);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_stall |=> point_valid && $stable(point_x)
      && $stable(point_y) && $stable(point_z) && $stable(last_point))
    else $error("stalled point changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !point_valid)
    else $error("point valid after reset");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    mid_walk |-> point_valid)
    else $error("gap inside a line");

  a_unit_step: assert property (@(posedge clk) disable iff (rst)
    mid_walk && point_valid |-> unit_x && unit_y && unit_z
      && !(step_x == '0 && step_y == '0 && step_z == '0))
    else $error("points of a line not adjacent");

  a_node_hold: assert property (@(posedge clk) disable iff (rst)
    node_valid && node_stall |=> node_valid && $stable(node_x)
      && $stable(node_y) && $stable(node_z) && $stable(new_path))
    else $error("stalled node changed");

endmodule

bind grid_line_path_walker_3d glpw_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

/* sim/grid_line_path_walker_3d_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_path_walker_3d_test
// Self-checking bench for the 3d grid line path walker. Directed paths cover
// the grid corners, every major axis, the axis tie rules, repeated nodes and
// a path opened without new_path. Random paths then follow, with random gaps
// and stalls on both channels and one long point hold-off that fills the
// node queue. Every point is checked against a line predictor kept in the
// bench.
// ----------------------------------------------------------------------------
module grid_line_path_walker_3d_test;

  localparam int CB          = glpw_pkg::COORD_BITS_DEF;
  localparam int CMIN        = -(1 << (CB - 1));
  localparam int CMAX        = (1 << (CB - 1)) - 1;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 last;
  } point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 node_valid = 1'b0;
  logic                 node_stall;
  logic signed [CB-1:0] node_x = '0;
  logic signed [CB-1:0] node_y = '0;
  logic signed [CB-1:0] node_z = '0;
  logic                 new_path = 1'b0;
  logic                 point_valid;
  logic                 point_stall = 1'b0;
  logic signed [CB-1:0] point_x;
  logic signed [CB-1:0] point_y;
  logic signed [CB-1:0] point_z;
  logic                 last_point;

  // predictor state
  point_t pending_points[$];
  int     prev_node[3];
  bit     have_prev;
  int     last_pt[3];
  bit     last_pt_valid;

  // idling control
  logic calm = 1'b0;
  logic hold_toggle = 1'b0;
  logic hold_seen;
  int   hold_len = 0;
  int   hold_left;
  int   stall_left;
  int   stall_roll;

  int     mismatches = 0;
  int     nodes_sent = 0;
  int     points_seen = 0;
  int     lines_seen = 0;
  int     backpressure_cycles = 0;
  int     cycle_count = 0;
  point_t want;

  grid_line_path_walker_3d #(.COORD_BITS(CB)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_x     (node_x),
    .node_y     (node_y),
    .node_z     (node_z),
    .new_path   (new_path),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 20)
      $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void add_point(input int p[3], ref point_t pts[$]);
    point_t pt;
    if (last_pt_valid && p[0] == last_pt[0] && p[1] == last_pt[1] && p[2] == last_pt[2])
      return;
    pt.x = CB'(p[0]);
    pt.y = CB'(p[1]);
    pt.z = CB'(p[2]);
    pt.last = 1'b0;
    pts.insert(pts.size(), pt);
    last_pt = p;
    last_pt_valid = 1'b1;
  endfunction

  // bresenham walk from the previous node, queued as expected points
  function automatic void trace_line(input int nx, input int ny, input int nz, input bit np);
    int         node[3];
    int         d[3];
    int         s[3];
    int         pos[3];
    int         err[2];
    logic [1:0] major;
    int         a;
    int         b;
    point_t     pts[$];
    node[0] = nx;
    node[1] = ny;
    node[2] = nz;
    if (np || !have_prev) begin
      prev_node = node;
      have_prev = 1'b1;
      last_pt_valid = 1'b0;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = node[i] - prev_node[i];
      s[i] = (d[i] > 0) ? 1 : ((d[i] < 0) ? -1 : 0);
      if (d[i] < 0) d[i] = -d[i];
      pos[i] = prev_node[i];
    end
    if (d[0] >= d[1] && d[0] >= d[2]) begin
      major = glpw_pkg::AXIS_X; a = 1; b = 2;
    end else if (d[1] >= d[2]) begin
      major = glpw_pkg::AXIS_Y; a = 0; b = 2;
    end else begin
      major = glpw_pkg::AXIS_Z; a = 0; b = 1;
    end
    err[0] = 2 * d[a] - d[major];
    err[1] = 2 * d[b] - d[major];
    while (pos[major] != node[major]) begin
      add_point(pos, pts);
      pos[major] += s[major];
      if (err[0] >= 0) begin
        pos[a] += s[a];
        err[0] -= 2 * d[major];
      end
      if (err[1] >= 0) begin
        pos[b] += s[b];
        err[1] -= 2 * d[major];
      end
      err[0] += 2 * d[a];
      err[1] += 2 * d[b];
    end
    add_point(node, pts);
    prev_node = node;
    if (pts.size() > 0) pts[pts.size() - 1].last = 1'b1;
    foreach (pts[i]) pending_points.insert(pending_points.size(), pts[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic int random_coord();
    return $urandom_range(0, CMAX - CMIN) + CMIN;
  endfunction

  function automatic int random_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 8) - 4;
    if (r < 9) return $urandom_range(0, 32) - 16;
    return $urandom_range(0, 126) - 63;
  endfunction

  // valid stays high on return; the next send with a gap or a drain lowers it
  task automatic send_node(input int x, input int y, input int z, input bit np);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      node_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    node_valid <= 1'b1;
    node_x <= CB'(x);
    node_y <= CB'(y);
    node_z <= CB'(z);
    new_path <= np;
    @(posedge clk);
    while (node_stall) @(posedge clk);
    trace_line(x, y, z, np);
    nodes_sent++;
  endtask

  task automatic drain_points();
    node_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      point_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= hold_len;
      point_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      point_stall <= 1'b1;
    end else if (calm) begin
      point_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        point_stall <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (stall_roll < 88) begin
        point_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_roll < 97) begin
        point_stall <= 1'b1;
        stall_left <= $urandom_range(3, 11);
      end else begin
        point_stall <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end
    end
  end

  // point checker
  always @(posedge clk) begin
    if (!rst) begin
      if (node_valid && node_stall) backpressure_cycles++;
      if (point_valid && !point_stall) begin
        points_seen++;
        if (last_point) lines_seen++;
        if (pending_points.size() == 0) begin
          flag_mismatch($sformatf("unexpected point (%0d,%0d,%0d) last %0b",
                                  point_x, point_y, point_z, last_point));
        end else begin
          want = pending_points.pop_front();
          if (point_x !== want.x)
            flag_mismatch($sformatf("point_x got %0d want %0d", point_x, want.x));
          if (point_y !== want.y)
            flag_mismatch($sformatf("point_y got %0d want %0d", point_y, want.y));
          if (point_z !== want.z)
            flag_mismatch($sformatf("point_z got %0d want %0d", point_z, want.z));
          if (last_point !== want.last)
            flag_mismatch($sformatf("last_point got %0b want %0b", last_point, want.last));
        end
      end
    end
  end

  // first node after reset opens a path even without new_path
  task automatic test_first_node_opens_path();
    send_node(0, 0, 0, 1'b0);
    send_node(3, 1, 0, 1'b0);
  endtask

  // corner to corner lines covering every major axis, longest walk included
  task automatic test_extreme_lines();
    send_node(CMIN, CMIN, CMIN, 1'b1);
    send_node(CMAX, CMAX, CMAX, 1'b0);
    send_node(CMAX, CMIN, 0, 1'b0);
    send_node(CMIN, CMIN, CMAX, 1'b0);
    send_node(0, 0, CMIN, 1'b0);
  endtask

  // repeated node emits once only while nothing was emitted in the path
  task automatic test_repeated_nodes();
    send_node(5, 5, 5, 1'b1);
    send_node(5, 5, 5, 1'b0);
    send_node(5, 5, 5, 1'b0);
    send_node(6, 5, 5, 1'b0);
    send_node(1, 2, 3, 1'b1);
    send_node(4, 2, 3, 1'b0);
  endtask

  // x wins ties with y and z, y wins ties with z
  task automatic test_axis_ties();
    send_node(0, 0, 0, 1'b1);
    send_node(1, 4, -4, 1'b0);
    send_node(-3, 0, 0, 1'b0);
    send_node(2, -5, 5, 1'b0);
    send_node(-4, 5, -3, 1'b0);
  endtask

  task automatic test_random_paths();
    int sent;
    int len;
    int x;
    int y;
    int z;
    sent = 0;
    while (sent < 95) begin
      calm <= ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_node(random_coord(), random_coord(), random_coord(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        x = random_coord();
        y = random_coord();
        z = random_coord();
        send_node(x, y, z, $urandom_range(0, 9) != 0);
        sent++;
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) != 0) begin
            x = clamp_coord(x + random_offset());
            y = clamp_coord(y + random_offset());
            z = clamp_coord(z + random_offset());
          end
          send_node(x, y, z, 1'b0);
          sent++;
        end
      end
    end
  endtask

  // receiver holds off while nodes keep coming, so the node queue fills
  task automatic test_input_backpressure();
    int x;
    calm <= 1'b1;
    hold_len <= 400;
    hold_toggle <= ~hold_toggle;
    send_node(-16, 0, 0, 1'b1);
    for (int i = 0; i < 20; i++) begin
      x = (i % 2 == 0) ? 15 : -16;
      send_node(x, $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10, 1'b0);
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_first_node_opens_path();
    test_extreme_lines();
    test_repeated_nodes();
    test_axis_ties();
    test_random_paths();
    test_input_backpressure();
    drain_points();
    $display("sent %0d nodes, checked %0d points over %0d lines", nodes_sent, points_seen,
             lines_seen);
    $display("node input held back for %0d cycles under point hold-off", backpressure_cycles);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
